FILE: src/tap_pkg.sv
// Package for the target address parser: word types, result codes, parse phases.
// Used by every module of the parser; depends on nothing.
package tap_pkg;

    localparam logic [1:0] K_HOST  = 2'd0;
    localparam logic [1:0] K_DONE  = 2'd1;
    localparam logic [1:0] K_BAD   = 2'd2;
    localparam logic [1:0] K_SHORT = 2'd3;

    localparam logic [1:0] AK_IPV4   = 2'd0;
    localparam logic [1:0] AK_DOMAIN = 2'd1;
    localparam logic [1:0] AK_IPV6   = 2'd2;

    localparam logic [7:0] TYPE_IPV4   = 8'h01;
    localparam logic [7:0] TYPE_DOMAIN = 8'h03;
    localparam logic [7:0] TYPE_IPV6   = 8'h04;

    localparam logic [7:0] LEN_IPV4 = 8'd4;
    localparam logic [7:0] LEN_IPV6 = 8'd16;

    typedef enum logic [2:0] {
        PH_TYPE = 3'd0,
        PH_LEN  = 3'd1,
        PH_HOST = 3'd2,
        PH_PHI  = 3'd3,
        PH_PLO  = 3'd4,
        PH_SKIP = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  host_byte;
        logic [7:0]  host_index;
        logic [1:0]  address_kind;
        logic [15:0] port;
        logic [8:0]  consumed;
        logic        run_end;
    } t_out_word;

    // up to two result words produced by one input word
    typedef struct packed {
        logic [1:0] cnt;
        t_out_word  first;
        t_out_word  second;
    } t_push;

endpackage

FILE: src/tap_parse.sv
// Header parse state and per-word result generation.
// Depends on tap_pkg.
module tap_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tap_pkg::t_in_word i_word,
    output tap_pkg::t_push    o_push
);

    tap_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_kind_seen, n_kind_seen;
    logic [7:0]      r_bytes_left, n_bytes_left;
    logic [7:0]      r_host_count, n_host_count;
    logic [7:0]      r_port_high, n_port_high;
    logic [8:0]      r_consumed, n_consumed;

    tap_pkg::t_out_word res, short_res;
    logic               res_v, ended, short_v;
    logic [7:0]         b;
    logic [7:0]         left_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tap_pkg::PH_TYPE;
            r_kind_seen  <= '0;
            r_bytes_left <= '0;
            r_host_count <= '0;
            r_port_high  <= '0;
            r_consumed   <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_kind_seen  <= n_kind_seen;
            r_bytes_left <= n_bytes_left;
            r_host_count <= n_host_count;
            r_port_high  <= n_port_high;
            r_consumed   <= n_consumed;
        end
    end

    always_comb begin
        b            = i_word.data_byte;
        left_dec     = r_bytes_left - 8'd1;
        n_phase      = r_phase;
        n_kind_seen  = r_kind_seen;
        n_bytes_left = r_bytes_left;
        n_host_count = r_host_count;
        n_port_high  = r_port_high;
        n_consumed   = r_consumed;
        res          = '0;
        res_v        = 1'b0;
        ended        = 1'b0;

        unique case (r_phase)
            tap_pkg::PH_LEN: begin
                n_consumed = r_consumed + 9'd1;
                if (b == 8'd0) begin
                    res.kind = tap_pkg::K_BAD;
                    res_v    = 1'b1;
                    ended    = 1'b1;
                end else begin
                    n_bytes_left = b;
                    n_phase      = tap_pkg::PH_HOST;
                end
            end
            tap_pkg::PH_HOST: begin
                n_consumed     = r_consumed + 9'd1;
                res.kind       = tap_pkg::K_HOST;
                res.host_byte  = b;
                res.host_index = r_host_count;
                res_v          = 1'b1;
                n_host_count   = r_host_count + 8'd1;
                n_bytes_left   = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = tap_pkg::PH_PHI;
                end
            end
            tap_pkg::PH_PHI: begin
                n_consumed  = r_consumed + 9'd1;
                n_port_high = b;
                n_phase     = tap_pkg::PH_PLO;
            end
            tap_pkg::PH_PLO: begin
                n_consumed       = r_consumed + 9'd1;
                res.kind         = tap_pkg::K_DONE;
                res.address_kind = r_kind_seen;
                res.port         = {r_port_high, b};
                res.consumed     = n_consumed;
                res_v            = 1'b1;
                ended            = 1'b1;
            end
            tap_pkg::PH_SKIP: begin
                ended = 1'b1;
            end
            default: begin
                n_consumed   = 9'd1;
                n_host_count = '0;
                n_bytes_left = '0;
                n_port_high  = '0;
                priority if (b == tap_pkg::TYPE_IPV4) begin
                    n_kind_seen  = tap_pkg::AK_IPV4;
                    n_bytes_left = tap_pkg::LEN_IPV4;
                    n_phase      = tap_pkg::PH_HOST;
                end else if (b == tap_pkg::TYPE_IPV6) begin
                    n_kind_seen  = tap_pkg::AK_IPV6;
                    n_bytes_left = tap_pkg::LEN_IPV6;
                    n_phase      = tap_pkg::PH_HOST;
                end else if (b == tap_pkg::TYPE_DOMAIN) begin
                    n_kind_seen = tap_pkg::AK_DOMAIN;
                    n_phase     = tap_pkg::PH_LEN;
                end else begin
                    n_kind_seen = tap_pkg::AK_IPV4;
                    res.kind    = tap_pkg::K_BAD;
                    res_v       = 1'b1;
                    ended       = 1'b1;
                end
            end
        endcase

        short_v = 1'b0;
        if (ended) begin
            n_phase = i_word.last_byte ? tap_pkg::PH_TYPE : tap_pkg::PH_SKIP;
        end else if (i_word.last_byte) begin
            short_v = 1'b1;
            n_phase = tap_pkg::PH_TYPE;
        end

        short_res         = '0;
        short_res.kind    = tap_pkg::K_SHORT;
        short_res.run_end = 1'b1;

        o_push.first         = res_v ? res : short_res;
        o_push.first.run_end = !(res_v && short_v);
        o_push.second        = short_res;
        o_push.cnt           = {1'b0, res_v} + {1'b0, short_v};
    end

endmodule

FILE: src/tap_fifo.sv
// Result queue: takes up to two words per cycle while i_en is high, hands out one when popped.
// Depends on tap_pkg.
module tap_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tap_pkg::t_push     i_push,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full2,
    output tap_pkg::t_out_word o_word
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tap_pkg::t_out_word r_mem [DEPTH];
    logic [PW-1:0]      r_wp, n_wp, r_rp, n_rp, wp1, wp2, rp1;
    logic [CW-1:0]      r_count, n_count;
    logic [1:0]         push_n;

    assign wp1 = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign wp2 = (wp1 == PW'(DEPTH - 1)) ? '0 : wp1 + 1'b1;
    assign rp1 = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_comb begin
        push_n  = i_en ? i_push.cnt : 2'd0;
        n_rp    = i_pop ? rp1 : r_rp;
        unique case (push_n)
            2'd1:    n_wp = wp1;
            2'd2:    n_wp = wp2;
            default: n_wp = r_wp;
        endcase
        n_count = r_count + CW'(push_n) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (push_n == 2'd2) begin
            r_mem[wp1] <= i_push.second;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full2 = (r_count > CW'(DEPTH - 2));
    assign o_word  = r_mem[r_rp];

endmodule

FILE: src/target_address_parser_top.sv
// Target address parser: a header byte per word; host, done or error words out.
// Result words are registered into the queue. Throughput: one input word per cycle;
// an input causes zero to two result words, which leave one per cycle unless the
// output stalls, via a DEPTH-word queue; input stalls when fewer than two queue
// slots are free. Reset: synchronous, active low, parser waits for a type byte
// and the queue is empty. Depends on tap_pkg, tap_parse, tap_fifo.
module target_address_parser_top #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tap_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tap_pkg::t_out_word o_out_word
);

    tap_pkg::t_push push;
    logic           in_acc, out_acc, full2;

    assign in_acc     = i_in_valid && !full2;
    assign out_acc    = o_out_valid && !i_out_stall;
    assign o_in_stall = full2;

    tap_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_acc),
        .i_word  (i_in_word),
        .o_push  (push)
    );

    tap_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_acc),
        .i_push  (push),
        .i_pop   (out_acc),
        .o_valid (o_out_valid),
        .o_full2 (full2),
        .o_word  (o_out_word)
    );

endmodule

FILE: src/tap_chk.sv
// Port-level checks for the target address parser, bound to the top level.
// Depends on tap_pkg and target_address_parser_top.
module tap_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tap_pkg::t_out_word o_out_word
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind != tap_pkg::K_HOST |-> o_out_word.run_end)
        else $error("status word not last of its run");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == tap_pkg::K_DONE |-> o_out_word.consumed >= 9'd5)
        else $error("completion with impossible header length");

    a_host_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == tap_pkg::K_HOST
        |-> o_out_word.port == 16'd0 && o_out_word.consumed == 9'd0)
        else $error("host byte word carries completion fields");

endmodule

bind target_address_parser_top tap_chk u_chk (.*);
